[sv/sme_pkg.sv]
// Shared types and constants of the stack machine executor.
// Used by the controller, the datapath and the top level; no dependencies.
package sme_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned PC_W   = 16;
  localparam int unsigned CMD_W  = 5;

  // Opcodes
  typedef enum logic [CMD_W-1:0] {
    OP_HALT    = 5'd0,
    OP_RESERVE = 5'd1,
    OP_PUSH    = 5'd2,
    OP_STORE   = 5'd3,
    OP_LOAD    = 5'd4,
    OP_READ    = 5'd5,
    OP_WRITE   = 5'd6,
    OP_NEG     = 5'd7,
    OP_SUB     = 5'd8,
    OP_ADD     = 5'd9,
    OP_MUL     = 5'd10,
    OP_DIV     = 5'd11,
    OP_EQ      = 5'd12,
    OP_NE      = 5'd13,
    OP_LT      = 5'd14,
    OP_LE      = 5'd15,
    OP_GT      = 5'd16,
    OP_GE      = 5'd17,
    OP_AND     = 5'd18,
    OP_OR      = 5'd19,
    OP_NOT     = 5'd20,
    OP_JUMP    = 5'd21,
    OP_JIF     = 5'd22
  } op_e;

  // Run status codes
  localparam logic [1:0] RUN_OK    = 2'd0;
  localparam logic [1:0] RUN_HALT  = 2'd1;
  localparam logic [1:0] RUN_UNK   = 2'd2;
  localparam logic [1:0] RUN_FAULT = 2'd3;

  // Commands from controller to datapath
  typedef struct packed {
    logic clr;        // write one zero word of the clearing pass
    logic take_in;    // latch the accepted request
    logic capture;    // latch the two top stack words
    logic ind_rd;     // steer read port A to the indirect address
    logic div_start;  // launch the divider
    logic commit;     // write stack, update machine state, latch result
    logic emit;       // move the result into the output register
  } ctrl_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic clr_last;
    logic defer_load;
    logic defer_mul;
    logic defer_div;
    logic div_done;
    logic out_free;
  } dp_sts_t;

endpackage

[sv/sme_ram.sv]
// Generic single-write, dual-read RAM with registered read data.
// No dependencies.
module sme_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  // Write and registered reads
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

[sv/sme_div.sv]
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on sme_pkg for the data width.
module sme_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [sme_pkg::DATA_W-1:0] dividend_i,
  input  logic [sme_pkg::DATA_W-1:0] divisor_i,
  output logic                       done_o,
  output logic [sme_pkg::DATA_W-1:0] quotient_o
);

  localparam int unsigned W   = sme_pkg::DATA_W;
  localparam int unsigned CNW = $clog2(W);

  logic           busy_q, busy_d;
  logic           done_q, done_d;
  logic [CNW-1:0] cnt_q, cnt_d;
  logic [W:0]     rem_q, rem_d;
  logic [W-1:0]   quo_q, quo_d;
  logic [W-1:0]   den_q, den_d;
  logic           neg_q, neg_d;
  logic [W:0]     rem_sh;
  logic [W:0]     diff;

  // One restoring step per cycle on magnitudes
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    neg_d  = neg_q;
    rem_sh = {rem_q[W-1:0], quo_q[W-1]};
    diff   = rem_sh - {1'b0, den_q};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i[W-1] ? (~dividend_i + 1'b1) : dividend_i;
      den_d  = divisor_i[W-1] ? (~divisor_i + 1'b1) : divisor_i;
      neg_d  = dividend_i[W-1] ^ divisor_i[W-1];
    end else if (busy_q) begin
      if (!diff[W]) begin
        rem_d = diff;
        quo_d = {quo_q[W-2:0], 1'b1};
      end else begin
        rem_d = rem_sh;
        quo_d = {quo_q[W-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNW'(W-1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
    neg_q <= neg_d;
  end

  assign done_o     = done_q;
  assign quotient_o = neg_q ? (~quo_q + 1'b1) : quo_q;

endmodule

[sv/sme_dp.sv]
// Datapath: stack RAM, machine registers, instruction decode, multiplier,
// divider and output register. Depends on sme_pkg, sme_ram and sme_div.
module sme_dp #(
  parameter int unsigned STACK_DEPTH   = 1024,
  parameter int unsigned PROGRAM_DEPTH = 65536
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [sme_pkg::CMD_W-1:0]   command_i,
  input  logic [sme_pkg::DATA_W-1:0]  operand_i,
  input  logic [sme_pkg::DATA_W-1:0]  input_number_i,
  input  sme_pkg::ctrl_cmd_t          ctrl_i,
  output sme_pkg::dp_sts_t            sts_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [1:0]                  status_o,
  output logic                        write_valid_o,
  output logic [sme_pkg::DATA_W-1:0]  write_value_o,
  output logic [sme_pkg::PC_W-1:0]    next_address_o
);

  localparam int unsigned W   = sme_pkg::DATA_W;
  localparam int unsigned PCW = sme_pkg::PC_W;
  localparam int unsigned AW  = $clog2(STACK_DEPTH);
  localparam int unsigned SPW = $clog2(STACK_DEPTH + 1);

  // Latched request and machine state
  logic [sme_pkg::CMD_W-1:0] cmd_q;
  logic [W-1:0]   opv_q, num_q, a_q, b_q, prod_q;
  logic [SPW-1:0] sp_q;
  logic [PCW-1:0] pc_q;
  logic [1:0]     run_q;
  logic [AW-1:0]  clr_cnt_q;

  // Pending result and output register
  logic [1:0]     res_status_q, out_status_q;
  logic           res_wv_q, out_wv_q;
  logic [W-1:0]   res_wval_q, out_wval_q;
  logic [PCW-1:0] res_next_q, out_next_q;
  logic           out_valid_q;

  // Decode results
  logic [1:0]     run_n;
  logic [PCW-1:0] pc_n, pc_seq;
  logic [SPW-1:0] sp_n, spm1, spm2;
  logic           wr, flt, wv, d_load, d_mul, d_div, underflow;
  logic [AW-1:0]  waddr;
  logic [W-1:0]   alu, wval, wdata;
  logic [1:0]     need;
  logic           a_ok, b_ok, opv_ok;
  logic signed [33:0] rsum;

  // RAM ports
  logic           ram_we;
  logic [AW-1:0]  ram_waddr, ram_ra, ram_rb;
  logic [W-1:0]   ram_wdata, rd_a, rd_b;
  logic           div_done;
  logic [W-1:0]   quot;

  assign spm1   = sp_q - 1'b1;
  assign spm2   = sp_q - 2'd2;
  assign pc_seq = (pc_q == PCW'(PROGRAM_DEPTH - 1)) ? '0 : pc_q + 1'b1;
  assign a_ok   = a_q < W'(STACK_DEPTH);
  assign b_ok   = b_q < W'(STACK_DEPTH);
  assign opv_ok = opv_q < W'(PROGRAM_DEPTH);
  assign rsum   = $signed({{(34-SPW){1'b0}}, sp_q}) + $signed({{2{opv_q[W-1]}}, opv_q});

  // Entries each opcode consumes
  always_comb begin
    need = 2'd0;
    if (cmd_q == sme_pkg::OP_STORE ||
        (cmd_q inside {[sme_pkg::OP_SUB:sme_pkg::OP_OR]})) begin
      need = 2'd2;
    end else if ((cmd_q inside {[sme_pkg::OP_LOAD:sme_pkg::OP_NEG]}) ||
                 cmd_q == sme_pkg::OP_NOT || cmd_q == sme_pkg::OP_JIF) begin
      need = 2'd1;
    end
  end
  assign underflow = sp_q < SPW'(need);

  // Decode one instruction against the captured top words
  always_comb begin
    run_n  = run_q;
    pc_n   = pc_seq;
    sp_n   = sp_q;
    wr     = 1'b0;
    waddr  = spm1[AW-1:0];
    alu    = '0;
    wv     = 1'b0;
    wval   = '0;
    flt    = 1'b0;
    d_load = 1'b0;
    d_mul  = 1'b0;
    d_div  = 1'b0;
    if (run_q != sme_pkg::RUN_OK) begin
      pc_n = pc_q;
    end else if (underflow) begin
      flt = 1'b1;
    end else begin
      case (cmd_q)
        sme_pkg::OP_HALT: begin
          run_n = sme_pkg::RUN_HALT;
          pc_n  = pc_q;
        end
        sme_pkg::OP_RESERVE: begin
          if (rsum < 0 || rsum > 34'(STACK_DEPTH)) flt = 1'b1;
          else sp_n = rsum[SPW-1:0];
        end
        sme_pkg::OP_PUSH: begin
          if (sp_q >= SPW'(STACK_DEPTH)) begin
            flt = 1'b1;
          end else begin
            wr    = 1'b1;
            waddr = sp_q[AW-1:0];
            alu   = opv_q;
            sp_n  = sp_q + 1'b1;
          end
        end
        sme_pkg::OP_STORE: begin
          if (!a_ok) begin
            flt = 1'b1;
          end else begin
            wr    = 1'b1;
            waddr = a_q[AW-1:0];
            alu   = b_q;
            sp_n  = spm2;
          end
        end
        sme_pkg::OP_LOAD: begin
          if (!b_ok) begin
            flt = 1'b1;
          end else begin
            wr     = 1'b1;
            d_load = 1'b1;
          end
        end
        sme_pkg::OP_READ: begin
          if (!b_ok) begin
            flt = 1'b1;
          end else begin
            wr    = 1'b1;
            waddr = b_q[AW-1:0];
            alu   = num_q;
            sp_n  = spm1;
          end
        end
        sme_pkg::OP_WRITE: begin
          wv   = 1'b1;
          wval = b_q;
          sp_n = spm1;
        end
        sme_pkg::OP_NEG: begin
          wr  = 1'b1;
          alu = ~b_q + 1'b1;
        end
        sme_pkg::OP_NOT: begin
          wr  = 1'b1;
          alu = W'(1) - b_q;
        end
        sme_pkg::OP_JUMP: begin
          if (!opv_ok) flt = 1'b1;
          else pc_n = opv_q[PCW-1:0];
        end
        sme_pkg::OP_JIF: begin
          if (b_q == '0) begin
            if (!opv_ok) flt = 1'b1;
            else pc_n = opv_q[PCW-1:0];
          end
          sp_n = spm1;
        end
        sme_pkg::OP_SUB, sme_pkg::OP_ADD, sme_pkg::OP_MUL, sme_pkg::OP_DIV,
        sme_pkg::OP_EQ, sme_pkg::OP_NE, sme_pkg::OP_LT, sme_pkg::OP_LE,
        sme_pkg::OP_GT, sme_pkg::OP_GE, sme_pkg::OP_AND, sme_pkg::OP_OR: begin
          wr    = 1'b1;
          waddr = spm2[AW-1:0];
          sp_n  = spm1;
          case (cmd_q)
            sme_pkg::OP_SUB: alu = a_q - b_q;
            sme_pkg::OP_ADD: alu = a_q + b_q;
            sme_pkg::OP_MUL: d_mul = 1'b1;
            sme_pkg::OP_DIV: begin
              if (b_q == '0) flt = 1'b1;
              else d_div = 1'b1;
            end
            sme_pkg::OP_EQ: alu = W'(a_q == b_q);
            sme_pkg::OP_NE: alu = W'(a_q != b_q);
            sme_pkg::OP_LT: alu = W'($signed(a_q) < $signed(b_q));
            sme_pkg::OP_LE: alu = W'($signed(a_q) <= $signed(b_q));
            sme_pkg::OP_GT: alu = W'($signed(a_q) > $signed(b_q));
            sme_pkg::OP_GE: alu = W'($signed(a_q) >= $signed(b_q));
            sme_pkg::OP_AND: alu = W'(a_q == W'(1) && b_q == W'(1));
            default: alu = W'(a_q == W'(1) || b_q == W'(1));
          endcase
        end
        default: begin
          run_n = sme_pkg::RUN_UNK;
          pc_n  = pc_q;
        end
      endcase
    end
    // Fault leaves the machine untouched apart from its status
    if (flt) begin
      run_n  = sme_pkg::RUN_FAULT;
      pc_n   = pc_q;
      sp_n   = sp_q;
      wr     = 1'b0;
      wv     = 1'b0;
      wval   = '0;
      d_load = 1'b0;
      d_mul  = 1'b0;
      d_div  = 1'b0;
    end
  end

  // Pick write data by the unit that produced it
  always_comb begin
    case (cmd_q)
      sme_pkg::OP_LOAD: wdata = rd_a;
      sme_pkg::OP_MUL:  wdata = prod_q;
      sme_pkg::OP_DIV:  wdata = quot;
      default:          wdata = alu;
    endcase
  end

  assign ram_we    = ctrl_i.clr || (ctrl_i.commit && wr);
  assign ram_waddr = ctrl_i.clr ? clr_cnt_q : waddr;
  assign ram_wdata = ctrl_i.clr ? '0 : wdata;
  assign ram_ra    = ctrl_i.ind_rd ? b_q[AW-1:0] : spm2[AW-1:0];
  assign ram_rb    = spm1[AW-1:0];

  sme_ram #(
    .WIDTH (W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (ram_wdata),
    .raddr_a_i (ram_ra),
    .raddr_b_i (ram_rb),
    .rdata_a_o (rd_a),
    .rdata_b_o (rd_b)
  );

  sme_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (ctrl_i.div_start),
    .dividend_i (a_q),
    .divisor_i  (b_q),
    .done_o     (div_done),
    .quotient_o (quot)
  );

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q        <= '0;
      pc_q        <= '0;
      run_q       <= sme_pkg::RUN_OK;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (ctrl_i.clr) clr_cnt_q <= clr_cnt_q + 1'b1;
      if (ctrl_i.commit) begin
        sp_q  <= sp_n;
        pc_q  <= pc_n;
        run_q <= run_n;
      end
      if (ctrl_i.emit) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (ctrl_i.take_in) begin
      cmd_q <= command_i;
      opv_q <= operand_i;
      num_q <= input_number_i;
    end
    if (ctrl_i.capture) begin
      a_q <= rd_a;
      b_q <= rd_b;
    end
    prod_q <= a_q * b_q;
    if (ctrl_i.commit) begin
      res_status_q <= run_n;
      res_wv_q     <= wv;
      res_wval_q   <= wval;
      res_next_q   <= pc_n;
    end
    if (ctrl_i.emit) begin
      out_status_q <= res_status_q;
      out_wv_q     <= res_wv_q;
      out_wval_q   <= res_wval_q;
      out_next_q   <= res_next_q;
    end
  end

  assign sts_o.clr_last   = clr_cnt_q == AW'(STACK_DEPTH - 1);
  assign sts_o.defer_load = d_load;
  assign sts_o.defer_mul  = d_mul;
  assign sts_o.defer_div  = d_div;
  assign sts_o.div_done   = div_done;
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign write_valid_o  = out_wv_q;
  assign write_value_o  = out_wval_q;
  assign next_address_o = out_next_q;

endmodule

[sv/sme_ctrl.sv]
// Controller state machine sequencing the clearing pass and each request.
// Depends on sme_pkg for the command and status structs.
module sme_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  sme_pkg::dp_sts_t   sts_i,
  output sme_pkg::ctrl_cmd_t ctrl_o
);

  typedef enum logic [8:0] {
    ST_CLEAR = 9'b000000001,
    ST_IDLE  = 9'b000000010,
    ST_READ  = 9'b000000100,
    ST_CAP   = 9'b000001000,
    ST_EXEC  = 9'b000010000,
    ST_LOAD  = 9'b000100000,
    ST_MUL   = 9'b001000000,
    ST_DIV   = 9'b010000000,
    ST_DONE  = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    ctrl_o     = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        ctrl_o.clr = 1'b1;
        if (sts_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctrl_o.take_in = 1'b1;
          state_d        = ST_READ;
        end
      end
      ST_READ: state_d = ST_CAP;
      ST_CAP: begin
        ctrl_o.capture = 1'b1;
        state_d        = ST_EXEC;
      end
      ST_EXEC: begin
        ctrl_o.ind_rd = 1'b1;
        if (sts_i.defer_load) begin
          state_d = ST_LOAD;
        end else if (sts_i.defer_mul) begin
          state_d = ST_MUL;
        end else if (sts_i.defer_div) begin
          ctrl_o.div_start = 1'b1;
          state_d          = ST_DIV;
        end else begin
          ctrl_o.commit = 1'b1;
          state_d       = ST_DONE;
        end
      end
      ST_LOAD, ST_MUL: begin
        ctrl_o.commit = 1'b1;
        state_d       = ST_DONE;
      end
      ST_DIV: begin
        if (sts_i.div_done) begin
          ctrl_o.commit = 1'b1;
          state_d       = ST_DONE;
        end
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          ctrl_o.emit = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[sv/stack_machine_execute_top.sv]
// Top level of the stack machine executor: stream ports and field packing.
// Depends on sme_pkg, sme_ctrl and sme_dp.
//
// Usage: each request on the slave stream is one instruction; each yields
// exactly one result on the master stream, in order. The machine keeps a
// word stack (also used for variables), a stack pointer, a program counter
// and a run status. After a halt, unknown opcode or fault, every further
// request only reports the frozen status and program counter.
// Timing: load and multiply pass through one extra state (extra memory read
// or multiplier register) and divide waits in its own state for the divider
// (one quotient bit per cycle in the divider). One request is in work at a
// time; the next is accepted once the result sits in the output register,
// so a waiting result does not block acceptance.
// Reset: the control registers clear; the stack RAM is then zeroed by a
// clearing pass over every word, during which s_axis_tready stays low.
// Stall: a result held by m_axis_tready low stays stable in the output
// register; the block then stalls at the end of the following request.
module stack_machine_execute_top #(
  parameter int unsigned STACK_DEPTH   = 1024,
  parameter int unsigned PROGRAM_DEPTH = 65536
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,  // command[4:0], operand[36:5], input_number[68:37]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata   // status[1:0], write_valid[2], write_value[34:3],
                                     // next_address[50:35]
);

  sme_pkg::ctrl_cmd_t ctrl;
  sme_pkg::dp_sts_t   sts;
  logic [1:0]                 status;
  logic                       write_valid;
  logic [sme_pkg::DATA_W-1:0] write_value;
  logic [sme_pkg::PC_W-1:0]   next_address;

  sme_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .ctrl_o     (ctrl)
  );

  sme_dp #(
    .STACK_DEPTH   (STACK_DEPTH),
    .PROGRAM_DEPTH (PROGRAM_DEPTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .command_i      (s_axis_tdata[4:0]),
    .operand_i      (s_axis_tdata[36:5]),
    .input_number_i (s_axis_tdata[68:37]),
    .ctrl_i         (ctrl),
    .sts_o          (sts),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .status_o       (status),
    .write_valid_o  (write_valid),
    .write_value_o  (write_value),
    .next_address_o (next_address)
  );

  // Pack result fields, zero fill to whole bytes
  assign m_axis_tdata = {5'd0, next_address, write_value, write_valid, status};

endmodule

[dv/testbench.sv]
// Self-checking testbench of the stack machine executor: stream stimulus,
// a predictor of stack, pointer, address and status, and an in-order check.
// Depends on sme_pkg and stack_machine_execute_top.
`timescale 1ns / 100ps

module testbench;
  import sme_pkg::*;

  localparam int unsigned STACK_WORDS = 1024;
  localparam int unsigned CYCLE_LIMIT = 500000;

  typedef struct {
    bit [1:0]  status;
    bit        wr_valid;
    bit [31:0] wr_value;
    bit [15:0] next_addr;
  } outcome_t;

  // Machine predictor plus the queue of outcomes still owed by the block
  class exec_scoreboard;
    bit [31:0]   words [STACK_WORDS];
    int unsigned depth;
    bit [15:0]   pc;
    bit [1:0]    run;
    outcome_t    owed [$];
    int unsigned errors;
    int unsigned checked;

    function bit [31:0] combine(bit [4:0] cmd, bit [31:0] a, bit [31:0] b);
      bit t;
      t = 1'b0;
      case (cmd)
        OP_SUB: return a - b;
        OP_ADD: return a + b;
        OP_MUL: return a * b;
        OP_DIV: begin
          // most negative over minus one wraps to itself
          if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF) return a;
          return $signed(a) / $signed(b);
        end
        OP_EQ:  t = (a == b);
        OP_NE:  t = (a != b);
        OP_LT:  t = ($signed(a) < $signed(b));
        OP_LE:  t = ($signed(a) <= $signed(b));
        OP_GT:  t = ($signed(a) > $signed(b));
        OP_GE:  t = ($signed(a) >= $signed(b));
        OP_AND: t = (a == 32'd1) && (b == 32'd1);
        default: t = (a == 32'd1) || (b == 32'd1);
      endcase
      return {31'd0, t};
    endfunction

    // Execute one accepted request and queue its outcome
    function void note_request(bit [4:0] cmd, bit [31:0] opv, bit [31:0] num);
      outcome_t    r;
      bit [31:0]   a;
      bit [31:0]   b;
      bit          fault;
      int unsigned need;
      longint      s;
      r = '{run, 1'b0, 32'd0, pc};
      if (run != RUN_OK) begin
        owed.push_back(r);
        return;
      end
      r.next_addr = pc + 16'd1;
      fault = 1'b0;
      need = 0;
      if (cmd >= OP_STORE && cmd <= OP_JIF && cmd != OP_JUMP)
        need = (cmd == OP_STORE || (cmd >= OP_SUB && cmd <= OP_OR)) ? 2 : 1;
      if (depth < need) begin
        fault = 1'b1;
      end else begin
        a = (depth >= 2) ? words[depth-2] : 32'd0;
        b = (depth >= 1) ? words[depth-1] : 32'd0;
        case (cmd)
          OP_HALT: begin
            run = RUN_HALT;
            r.next_addr = pc;
          end
          OP_RESERVE: begin
            s = longint'(depth) + longint'($signed(opv));
            if (s < 0 || s > STACK_WORDS) fault = 1'b1;
            else depth = s;
          end
          OP_PUSH: begin
            if (depth >= STACK_WORDS) fault = 1'b1;
            else begin
              words[depth] = opv;
              depth++;
            end
          end
          OP_STORE: begin
            if (a >= STACK_WORDS) fault = 1'b1;
            else begin
              words[a[9:0]] = b;
              depth -= 2;
            end
          end
          OP_LOAD: begin
            if (b >= STACK_WORDS) fault = 1'b1;
            else words[depth-1] = words[b[9:0]];
          end
          OP_READ: begin
            if (b >= STACK_WORDS) fault = 1'b1;
            else begin
              words[b[9:0]] = num;
              depth--;
            end
          end
          OP_WRITE: begin
            r.wr_valid = 1'b1;
            r.wr_value = b;
            depth--;
          end
          OP_NEG: words[depth-1] = -b;
          OP_NOT: words[depth-1] = 32'd1 - b;
          OP_JUMP: begin
            if (opv >= 32'h1_0000) fault = 1'b1;
            else r.next_addr = opv[15:0];
          end
          OP_JIF: begin
            // target matters only when the branch is taken
            if (b == 32'd0) begin
              if (opv >= 32'h1_0000) fault = 1'b1;
              else r.next_addr = opv[15:0];
            end
            if (!fault) depth--;
          end
          OP_SUB, OP_ADD, OP_MUL, OP_DIV, OP_EQ, OP_NE, OP_LT, OP_LE, OP_GT,
          OP_GE, OP_AND, OP_OR: begin
            if (cmd == OP_DIV && b == 32'd0) fault = 1'b1;
            else begin
              words[depth-2] = combine(cmd, a, b);
              depth--;
            end
          end
          default: begin
            run = RUN_UNK;
            r.next_addr = pc;
          end
        endcase
      end
      if (fault) begin
        run = RUN_FAULT;
        r.next_addr = pc;
        r.wr_valid = 1'b0;
        r.wr_value = 32'd0;
      end
      pc = r.next_addr;
      r.status = run;
      owed.push_back(r);
    endfunction

    function void compare_field(string name, bit [31:0] exp_v, bit [31:0] act_v);
      if (exp_v !== act_v) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
        errors++;
      end
    endfunction

    // Match one accepted result against the oldest owed outcome
    function void check_result(bit [55:0] d);
      outcome_t e;
      if (owed.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %0h", $time, d);
        errors++;
        return;
      end
      e = owed.pop_front();
      checked++;
      compare_field("status", e.status, d[1:0]);
      compare_field("write_valid", e.wr_valid, d[2]);
      compare_field("write_value", e.wr_value, d[34:3]);
      compare_field("next_address", e.next_addr, d[50:35]);
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata;   // command[4:0], operand[36:5], input_number[68:37]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [55:0] m_axis_tdata;   // status[1:0], write_valid[2], write_value[34:3],
                               // next_address[50:35]

  exec_scoreboard sb;
  bit          quiet;
  bit          hold_req;
  int unsigned cycles;
  int unsigned sent;
  string       ending;

  stack_machine_execute_top u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #4 clk_i = ~clk_i;

  // Cycle count and watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Check every accepted result
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
  end

  // Result back-pressure: random bursts, one long hold on request
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (300) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  function automatic bit [31:0] any_word();
    case ($urandom_range(0, 3))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0;
      default: return $urandom;
    endcase
  endfunction

  // Offer one request, wait for its handshake, then maybe idle a burst
  task automatic send_op(bit [4:0] cmd, bit [31:0] opv, bit [31:0] num);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'd0, num, opv, cmd};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_request(cmd, opv, num);
    sent++;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  endtask

  // Choose an instruction that keeps the machine running
  function automatic void pick_running(output bit [4:0] cmd, output bit [31:0] opv);
    int unsigned d;
    bit [31:0]   a;
    bit [31:0]   b;
    bit          ok;
    d = sb.depth;
    a = (d >= 2) ? sb.words[d-2] : 32'd0;
    b = (d >= 1) ? sb.words[d-1] : 32'd0;
    opv = any_word();
    for (int tries = 0; tries < 12; tries++) begin
      cmd = $urandom_range(OP_RESERVE, OP_JIF);
      case (cmd)
        OP_RESERVE: begin
          case ($urandom_range(0, 9))
            0: opv = STACK_WORDS - d;
            1: opv = -d;
            default: opv = $urandom_range(0, 3) - 1;
          endcase
          ok = (int'(d) + $signed(opv) >= 0) && (int'(d) + $signed(opv) <= STACK_WORDS);
        end
        OP_PUSH: begin
          ok = (d < STACK_WORDS);
          if ($urandom_range(0, 1)) opv = $urandom_range(0, d + 3);
        end
        OP_STORE: ok = (d >= 2) && (a < STACK_WORDS);
        OP_LOAD, OP_READ: ok = (d >= 1) && (b < STACK_WORDS);
        OP_WRITE, OP_NEG, OP_NOT: ok = (d >= 1);
        OP_DIV: ok = (d >= 2) && (b != 32'd0);
        OP_JUMP: begin
          ok = 1'b1;
          opv = $urandom_range(0, 65535);
        end
        OP_JIF: begin
          ok = (d >= 1);
          if (b == 32'd0) opv = $urandom_range(0, 65535);
        end
        default: ok = (d >= 2);
      endcase
      if (ok) return;
    end
    // fall back to something always legal
    if (d < STACK_WORDS) begin
      cmd = OP_PUSH;
      opv = $urandom_range(0, 1) ? $urandom_range(0, d + 3) : any_word();
    end else begin
      cmd = OP_WRITE;
    end
  endfunction

  task automatic run_random(int unsigned count);
    bit [4:0]  cmd;
    bit [31:0] opv;
    repeat (count) begin
      pick_running(cmd, opv);
      send_op(cmd, opv, any_word());
    end
  endtask

  task automatic wait_drained();
    while (sb.owed.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    sb = new();
    clk_i = 1'b0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    quiet = 1'b0;
    hold_req = 1'b0;
    cycles = 0;
    sent = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Add of the largest and most negative words, most negative over minus one, negate of the minimum
    send_op(OP_PUSH, 32'h7FFF_FFFF, 32'd0);
    send_op(OP_PUSH, 32'h8000_0000, 32'hFFFF_FFFF);
    send_op(OP_ADD, 32'd0, 32'd0);
    send_op(OP_WRITE, 32'd0, 32'd0);
    send_op(OP_PUSH, 32'h8000_0000, 32'd0);
    send_op(OP_PUSH, 32'hFFFF_FFFF, 32'd0);
    send_op(OP_DIV, 32'd0, 32'd0);
    send_op(OP_NEG, 32'd0, 32'd0);
    // Truncating division of a negative number
    send_op(OP_PUSH, 32'hFFFF_FFF9, 32'd0);
    send_op(OP_PUSH, 32'd2, 32'd0);
    send_op(OP_DIV, 32'd0, 32'd0);
    send_op(OP_SUB, 32'd0, 32'd0);
    send_op(OP_WRITE, 32'd0, 32'd0);
    // Fill the stack with a reserve, then release it with a negative reserve
    send_op(OP_RESERVE, STACK_WORDS, 32'd0);
    send_op(OP_RESERVE, -STACK_WORDS, 32'd0);
    // Indirect store, read and load
    send_op(OP_PUSH, 32'd3, 32'd0);
    send_op(OP_PUSH, 32'd9, 32'd0);
    send_op(OP_STORE, 32'd0, 32'd0);
    send_op(OP_PUSH, 32'd4, 32'd0);
    send_op(OP_READ, 32'd0, 32'hDEAD_BEEF);
    send_op(OP_PUSH, 32'd3, 32'd0);
    send_op(OP_LOAD, 32'd0, 32'd0);
    send_op(OP_WRITE, 32'd0, 32'd0);
    // Sequential address wraps past the top of program space
    send_op(OP_JUMP, 32'd65535, 32'd0);
    send_op(OP_PUSH, 32'd0, 32'd0);
    send_op(OP_JIF, 32'd100, 32'd0);

    run_random(700);
    // Pause the sender until the block is empty
    s_axis_tvalid <= 1'b0;
    wait_drained();
    @(posedge clk_i);
    // Long result stall while requests keep coming
    hold_req = 1'b1;
    run_random(400);
    quiet = 1'b1;
    run_random(500);

    // End the run with one of halt, unknown opcode or fault
    case ($urandom_range(0, 2))
      0: begin
        ending = "halt";
        send_op(OP_HALT, $urandom, $urandom);
      end
      1: begin
        ending = "unknown opcode";
        send_op($urandom_range(OP_JIF + 1, 31), $urandom, $urandom);
      end
      default: begin
        ending = "fault";
        if (sb.depth == 0) send_op(OP_WRITE, 32'd0, 32'd0);
        else send_op(OP_JUMP, 32'h0001_0000, 32'd0);
      end
    endcase
    // Requests after a stop only report the frozen state
    repeat (12) send_op($urandom_range(0, 31), $urandom, $urandom);
    s_axis_tvalid <= 1'b0;

    wait_drained();
    repeat (60) @(posedge clk_i);
    $display("Ran %0d instructions, %0d results checked, stopped by %s.",
             sent, sb.checked, ending);
    if (sb.errors == 0 && sb.owed.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
